/* rtl/core/lbsp_pkg.sv */
package lbsp_pkg;

   localparam int CHAN_W      = 8;
   localparam int PIX_W       = 3 * CHAN_W;
   localparam int WIN_N       = 5;
   localparam int LINES       = 4;
   localparam int DESC_W      = 16;
   localparam int CX_W        = 10;
   localparam int ROW_W       = 12;
   localparam int CFG_WIDTH_W = 11;
   localparam int CFG_DATA_W  = 11;
   localparam int CSR_IDX_W   = 2;
   localparam int MIN_WIDTH   = 5;
   localparam int DESC_START  = 4;
   localparam int CENTER_OFS  = 2;

   localparam logic [ROW_W-1:0]       ROW_MAX         = 12'd4095;
   localparam logic [CFG_WIDTH_W-1:0] WIDTH_RESET     = 11'd640;
   localparam logic [CHAN_W-1:0]      REL_RESET       = 8'd93;
   localparam logic [CHAN_W-1:0]      OFFSET_RESET    = 8'd0;

   typedef logic [PIX_W-1:0] pix_type;
   typedef pix_type [WIN_N-1:0] col_type;   // indexed by window row
   typedef col_type [WIN_N-1:0] win_type;   // indexed by window column

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH      = 2'd0,
      CSR_REL_THRESHOLD    = 2'd1,
      CSR_THRESHOLD_OFFSET = 2'd2
   } csr_index_type;

   // Window column and row of the neighbor for descriptor bit 15 - k.
   localparam logic [2:0] NB_COL [16] = '{
      3'd1, 3'd3, 3'd3, 3'd1, 3'd3, 3'd2, 3'd1, 3'd2,
      3'd0, 3'd4, 3'd4, 3'd0, 3'd2, 3'd2, 3'd4, 3'd0
   };
   localparam logic [2:0] NB_ROW [16] = '{
      3'd3, 3'd1, 3'd3, 3'd1, 3'd2, 3'd1, 3'd2, 3'd3,
      3'd0, 3'd4, 3'd0, 3'd4, 3'd4, 3'd0, 3'd2, 3'd2
   };

endpackage

/* rtl/core/lbsp_if.sv */
interface lbsp_req_if;
   import lbsp_pkg::*;
   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;
   logic              frame_start;

   modport source (output valid, red, green, blue, frame_start, input ready);
   modport sink   (input valid, red, green, blue, frame_start, output ready);
endinterface

interface lbsp_rsp_if;
   import lbsp_pkg::*;
   logic              valid;
   logic              ready;
   logic [DESC_W-1:0] desc_red;
   logic [DESC_W-1:0] desc_green;
   logic [DESC_W-1:0] desc_blue;
   logic [CX_W-1:0]   center_x;
   logic [ROW_W-1:0]  center_y;

   modport source (output valid, desc_red, desc_green, desc_blue, center_x, center_y,
                   input ready);
   modport sink   (input valid, desc_red, desc_green, desc_blue, center_x, center_y,
                   output ready);
endinterface

interface lbsp_csr_if;
   import lbsp_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CFG_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/core/lbsp_rgb_descriptor_stream.sv */
// Channel   Dir  Beat contents
// req_ch    in   red, green, blue, frame_start  (one pixel, raster order)
// rsp_ch    out  desc_red, desc_green, desc_blue, center_x, center_y
// csr_ch    in   index, data  (0 image_width, 1 rel_threshold_q8, 2 threshold_offset)
//
// One pixel is taken per clock while rsp_ch does not stall. A result leaves the output register
// after its pixel passes line store read, window column shift and descriptor compare.
// Reset is synchronous; the line store is not cleared and needs none.
// A stalled rsp_ch fills the output, window and line-read stages before req_ch.ready drops.
module lbsp_rgb_descriptor_stream
   import lbsp_pkg::*;
#(
   parameter int MAX_WIDTH = 1024
)
(
   input logic         clock,
   input logic         reset,
   lbsp_req_if.sink    req_ch,
   lbsp_rsp_if.source  rsp_ch,
   lbsp_csr_if.sink    csr_ch
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int CW = (XW + 1 > CFG_WIDTH_W) ? XW + 1 : CFG_WIDTH_W;
   localparam int WORD_W = LINES * PIX_W;
   localparam logic [CW-1:0] MAX_W_C = CW'(MAX_WIDTH);
   localparam logic [CW-1:0] MIN_W_C = CW'(MIN_WIDTH);

   // Configuration registers.
   logic [CFG_WIDTH_W-1:0] width_ff, width_in;
   logic [CHAN_W-1:0]      rel_ff, rel_in;
   logic [CHAN_W-1:0]      offset_ff, offset_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      width_in  = width_ff;
      rel_in    = rel_ff;
      offset_in = offset_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_IMAGE_WIDTH:      width_in  = csr_ch.data[CFG_WIDTH_W-1:0];
            CSR_REL_THRESHOLD:    rel_in    = csr_ch.data[CHAN_W-1:0];
            CSR_THRESHOLD_OFFSET: offset_in = csr_ch.data[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         rel_ff    <= REL_RESET;
         offset_ff <= OFFSET_RESET;
      end else begin
         width_ff  <= width_in;
         rel_ff    <= rel_in;
         offset_ff <= offset_in;
      end
   end

   // Pipeline flow control.
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic out_valid_ff, out_valid_in;
   logic out_load, s2_free, s1_move, s1_free, accept;

   assign out_load = s2_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign s2_free  = !s2_valid_ff || out_load;
   assign s1_move  = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s1_move;
   assign req_ch.ready = s1_free;
   assign accept   = req_ch.valid && s1_free;

   // Position of the incoming pixel.
   logic [XW-1:0]    col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [CW-1:0]    width_eff, width_ext, x1_ext, xp1, cx_sub;
   logic [XW-1:0]    x0, x1;
   logic [ROW_W-1:0] y0, y1;
   logic             emit;
   logic [CX_W-1:0]  cx;
   logic [ROW_W-1:0] cy;

   always_comb begin
      width_ext = CW'(width_ff);
      if (width_ext < MIN_W_C) begin
         width_eff = MIN_W_C;
      end else if (width_ext > MAX_W_C) begin
         width_eff = MAX_W_C;
      end else begin
         width_eff = width_ext;
      end

      x0 = req_ch.frame_start ? '0 : col_ff;
      y0 = req_ch.frame_start ? '0 : row_ff;
      // A column left beyond a narrowed width wraps to the next row.
      if (CW'(x0) >= width_eff) begin
         x1 = '0;
         y1 = (y0 < ROW_MAX) ? y0 + 1'b1 : y0;
      end else begin
         x1 = x0;
         y1 = y0;
      end
      x1_ext = CW'(x1);
      emit   = (x1_ext >= CW'(DESC_START)) && (y1 >= ROW_W'(DESC_START));
      cx_sub = x1_ext - CW'(CENTER_OFS);
      cx     = cx_sub[CX_W-1:0];
      cy     = y1 - ROW_W'(CENTER_OFS);

      xp1 = x1_ext + 1'b1;
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (xp1 >= width_eff) begin
            col_in = '0;
            row_in = (y1 < ROW_MAX) ? y1 + 1'b1 : y1;
         end else begin
            col_in = xp1[XW-1:0];
            row_in = y1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage 1: line store read. One word per column holds the four older lines.
   logic [WORD_W-1:0] line_mem [MAX_WIDTH];
   logic [WORD_W-1:0] mem_q_ff;
   logic [WORD_W-1:0] byp_word_ff;
   logic              byp_ff, byp_in;
   logic [XW-1:0]     s1_x_ff;
   pix_type           s1_pix_ff;
   logic              s1_emit_ff;
   logic [CX_W-1:0]   s1_cx_ff;
   logic [ROW_W-1:0]  s1_cy_ff;
   logic [WORD_W-1:0] old_word, wr_word;
   col_type           new_col;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         line_mem[s1_x_ff] <= wr_word;
      end
      if (accept) begin
         mem_q_ff <= line_mem[x1];
      end
   end

   // The write of the item ahead lands on the same edge as this read; forward it.
   always_comb begin
      byp_in = byp_ff;
      if (accept) begin
         byp_in = s1_move && (s1_x_ff == x1);
      end else if (s1_move) begin
         byp_in = 1'b0;
      end
      s1_valid_in = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         byp_ff      <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         byp_ff      <= byp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byp_word_ff <= wr_word;
         s1_x_ff     <= x1;
         s1_pix_ff   <= {req_ch.blue, req_ch.green, req_ch.red};
         s1_emit_ff  <= emit;
         s1_cx_ff    <= cx;
         s1_cy_ff    <= cy;
      end
   end

   always_comb begin
      old_word = byp_ff ? byp_word_ff : mem_q_ff;
      wr_word  = {old_word[WORD_W-PIX_W-1:0], s1_pix_ff};
      new_col[0] = old_word[4*PIX_W-1:3*PIX_W];
      new_col[1] = old_word[3*PIX_W-1:2*PIX_W];
      new_col[2] = old_word[2*PIX_W-1:PIX_W];
      new_col[3] = old_word[PIX_W-1:0];
      new_col[4] = s1_pix_ff;
   end

   // Stage 2: window as a chain of column cells, shifting toward column 0.
   win_type win;

   for (genvar j = 0; j < WIN_N; j++) begin : g_cell
      if (j == WIN_N - 1) begin : g_head
         lbsp_col_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (s1_move),
            .col_in  (new_col),
            .col_out (win[j])
         );
      end else begin : g_body
         lbsp_col_cell u_cell (
            .clock   (clock),
            .reset   (reset),
            .shift   (s1_move),
            .col_in  (win[j+1]),
            .col_out (win[j])
         );
      end
   end

   logic [CX_W-1:0]  s2_cx_ff;
   logic [ROW_W-1:0] s2_cy_ff;

   always_comb begin
      s2_valid_in = s1_move ? s1_emit_ff : (out_load ? 1'b0 : s2_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         s2_cx_ff <= s1_cx_ff;
         s2_cy_ff <= s1_cy_ff;
      end
   end

   // Stage 3: descriptor compare into the output register.
   logic [2:0][DESC_W-1:0] desc;

   lbsp_desc u_desc (
      .win    (win),
      .rel    (rel_ff),
      .offset (offset_ff),
      .desc   (desc)
   );

   logic [2:0][DESC_W-1:0] out_desc_ff;
   logic [CX_W-1:0]        out_cx_ff;
   logic [ROW_W-1:0]       out_cy_ff;

   always_comb begin
      out_valid_in = out_load ? 1'b1 : ((rsp_ch.ready) ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_desc_ff <= desc;
         out_cx_ff   <= s2_cx_ff;
         out_cy_ff   <= s2_cy_ff;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.desc_red   = out_desc_ff[0];
   assign rsp_ch.desc_green = out_desc_ff[1];
   assign rsp_ch.desc_blue  = out_desc_ff[2];
   assign rsp_ch.center_x   = out_cx_ff;
   assign rsp_ch.center_y   = out_cy_ff;

   a_byp_needs_item: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> s1_valid_ff)
      else $error("line store forward flag set with no item in the read stage");

   a_emit_column: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_emit_ff) |-> (CW'(s1_x_ff) >= CW'(DESC_START)))
      else $error("result flagged for a column left of the full window");

   a_window_free: assert property (@(posedge clock) disable iff (reset)
      s1_move |-> (!s2_valid_ff || out_load))
      else $error("window shifted while its pending result was still held");

   a_center_range: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((rsp_ch.center_x >= CX_W'(CENTER_OFS))
                        && (rsp_ch.center_y >= ROW_W'(CENTER_OFS))))
      else $error("result center lies on the image border");

   a_load_after_move: assert property (@(posedge clock) disable iff (reset)
      (s1_move && s1_emit_ff) |=> s2_valid_ff)
      else $error("result lost between window shift and compare stage");

endmodule

/* rtl/core/lbsp_col_cell.sv */
module lbsp_col_cell
   import lbsp_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    shift,
   input  col_type col_in,
   output col_type col_out
);

   col_type col_ff;
   col_type col_in_next;

   always_comb begin
      col_in_next = shift ? col_in : col_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
      end else begin
         col_ff <= col_in_next;
      end
   end

   assign col_out = col_ff;

endmodule

/* rtl/core/lbsp_desc.sv */
module lbsp_desc
   import lbsp_pkg::*;
(
   input  win_type                        win,
   input  logic [CHAN_W-1:0]              rel,
   input  logic [CHAN_W-1:0]              offset,
   output logic [2:0][DESC_W-1:0]         desc
);

   always_comb begin
      logic [CHAN_W-1:0]   c;
      logic [CHAN_W-1:0]   n;
      logic [CHAN_W-1:0]   d;
      logic [CHAN_W-1:0]   t;
      logic [2*CHAN_W-1:0] prod;
      logic [CHAN_W:0]     tsum;
      desc = '0;
      for (int ch = 0; ch < 3; ch++) begin
         c    = win[2][2][CHAN_W*ch +: CHAN_W];
         prod = c * rel;
         tsum = {1'b0, prod[2*CHAN_W-1:CHAN_W]} + {1'b0, offset};
         t    = tsum[CHAN_W] ? {CHAN_W{1'b1}} : tsum[CHAN_W-1:0];
         for (int k = 0; k < DESC_W; k++) begin
            n = win[NB_COL[k]][NB_ROW[k]][CHAN_W*ch +: CHAN_W];
            d = (n > c) ? (n - c) : (c - n);
            desc[ch][DESC_W-1-k] = (d > t);
         end
      end
   end

endmodule
